// ===== rtl/core/tsvg_pkg.sv =====
// ============================================================================
// tsvg_pkg
// Shared constants, types and the divider step for the two-segment gradient.
// ============================================================================
package tsvg_pkg;

    localparam int MAX_ROWS  = 8192;
    localparam int ROW_W     = 13;
    localparam int HEIGHT_W  = 14;
    localparam int COLOR_W   = 24;
    localparam int CHAN_W    = 8;
    localparam int LANES     = 3;
    localparam int FRAC_W    = 16;
    localparam int QUO_W     = CHAN_W + FRAC_W;
    localparam int DIV_BITS  = 4;
    localparam int DIV_STAGES = QUO_W / DIV_BITS;
    localparam int PROD_W    = QUO_W + ROW_W;
    localparam int NUM_STAGES = DIV_STAGES + 3;

    localparam int SPLIT_NUM   = 132;
    localparam int SPLIT_DEN   = 255;
    localparam int SPLIT_SHIFT = 29;
    localparam longint SPLIT_RECIP =
        ((longint'(1) << SPLIT_SHIFT) + SPLIT_DEN - 1) / SPLIT_DEN;
    localparam longint SPLIT_MUL = SPLIT_NUM * SPLIT_RECIP;
    localparam int SPLIT_MUL_W = 29;
    localparam int SPLIT_PROD_W = ROW_W + SPLIT_MUL_W;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [1:0] {
        REG_TOP_COLOR    = 2'd0,
        REG_MIDDLE_COLOR = 2'd1,
        REG_BOTTOM_COLOR = 2'd2,
        REG_FRAME_HEIGHT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [COLOR_W-1:0]  top;
        logic [COLOR_W-1:0]  middle;
        logic [COLOR_W-1:0]  bottom;
        logic [HEIGHT_W-1:0] height;
        logic [ROW_W-1:0]    split;
        logic [ROW_W-1:0]    len_lo;
    } t_cfg;

    typedef struct packed {
        logic [ROW_W-1:0]  rem;
        logic [QUO_W-1:0]  w;
        logic [CHAN_W-1:0] s;
        logic              neg;
    } t_lane;

    typedef struct packed {
        t_lane [LANES-1:0] lane;
        logic [ROW_W-1:0]  den;
        logic [ROW_W-1:0]  k;
        logic              nul;
        logic              oor;
        logic              last;
    } t_div_item;

    typedef struct packed {
        logic [LANES-1:0][PROD_W-1:0] prod;
        logic [LANES-1:0][CHAN_W-1:0] s;
        logic [LANES-1:0]             neg;
        logic                         oor;
        logic                         last;
    } t_mul_item;

    // Restoring division, DIV_BITS quotient bits per call. The quotient bits
    // shift into the low end of w as the dividend bits leave its high end.
    function automatic t_lane div_steps(t_lane a, logic [ROW_W-1:0] den);
        t_lane       r;
        logic [ROW_W:0] t;
        r = a;
        for (int i = 0; i < DIV_BITS; i++) begin
            t = {r.rem, r.w[QUO_W-1]};
            r.w = {r.w[QUO_W-2:0], 1'b0};
            if (t >= {1'b0, den}) begin
                r.rem = ROW_W'(t - {1'b0, den});
                r.w[0] = 1'b1;
            end else begin
                r.rem = t[ROW_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/tsvg_cfg.sv =====
// ============================================================================
// tsvg_cfg
// Configuration registers and the derived split row and lower segment length.
// ============================================================================
module tsvg_cfg
    import tsvg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [COLOR_W-1:0] i_cfg_data,
    output t_cfg               o_cfg
);

    t_cfg                    r_cfg;
    t_cfg                    n_cfg;
    logic [HEIGHT_W-1:0]     h_sat;
    logic [ROW_W-1:0]        hm1;
    logic [SPLIT_PROD_W-1:0] split_prod;
    logic [ROW_W-1:0]        split;

    always_comb begin
        h_sat = i_cfg_data[HEIGHT_W-1:0];
        if (h_sat > HEIGHT_W'(MAX_ROWS)) begin
            h_sat = HEIGHT_W'(MAX_ROWS);
        end
        hm1 = ROW_W'(h_sat - HEIGHT_W'(1));
        split_prod = SPLIT_PROD_W'(hm1) * SPLIT_PROD_W'(SPLIT_MUL);
        split = split_prod[SPLIT_SHIFT +: ROW_W];
    end

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_TOP_COLOR: begin
                    n_cfg.top = i_cfg_data;
                end
                REG_MIDDLE_COLOR: begin
                    n_cfg.middle = i_cfg_data;
                end
                REG_BOTTOM_COLOR: begin
                    n_cfg.bottom = i_cfg_data;
                end
                REG_FRAME_HEIGHT: begin
                    n_cfg.height = h_sat;
                    n_cfg.split  = split;
                    n_cfg.len_lo = hm1 - split;
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.top    <= '0;
            r_cfg.middle <= '0;
            r_cfg.bottom <= '0;
            r_cfg.height <= HEIGHT_W'(1);
            r_cfg.split  <= '0;
            r_cfg.len_lo <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

    a_split_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cfg.height != '0) |->
        (HEIGHT_W'(r_cfg.split) + HEIGHT_W'(r_cfg.len_lo) + HEIGHT_W'(1) == r_cfg.height))
        else $error("split and lower length do not add up to the height");

    a_height_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cfg.height <= HEIGHT_W'(MAX_ROWS))
        else $error("frame height above the row limit");

endmodule

// ===== rtl/core/two_segment_vertical_gradient.sv =====
// ============================================================================
// two_segment_vertical_gradient
// Row color of a two-segment vertical gradient, one row per cycle unless stalled.
// ============================================================================
//  Channel   Direction  Payload
//  cfg       in         i_cfg_idx (register), i_cfg_data (value)
//  s_axis    in         tdata: row_index
//  m_axis    out        tdata: pixel_color, tlast: last_row, tuser: out_of_range
//
// A row passes nine register stages: one setup stage, six divider stages of
// four quotient bits each, one multiply stage and the output register. One row
// enters per cycle unless an output stall has backed up to the input.
// Reset clears the stage valid bits and loads the default configuration.
// An output stall holds the full stages next to the output; a bubble and the
// stages before it still advance.
// ============================================================================
module two_segment_vertical_gradient
    import tsvg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [COLOR_W-1:0] i_cfg_data,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [15:0]        i_s_axis_tdata,  // [12:0] row_index
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [31:0]        o_m_axis_tdata,  // [31:0] pixel_color
    output logic               o_m_axis_tlast,
    output logic               o_m_axis_tuser   // [0] out_of_range
);

    localparam int MUL_ST = DIV_STAGES + 1;
    localparam int OUT_ST = DIV_STAGES + 2;

    t_cfg                   cfg;
    logic [NUM_STAGES-1:0]  r_v;
    logic [NUM_STAGES-1:0]  ld;
    t_div_item              r_d [0:DIV_STAGES];
    t_div_item              n_d [0:DIV_STAGES];
    t_mul_item              r_m;
    t_mul_item              n_m;
    logic [31:0]            r_pix;
    logic                   r_last;
    logic                   r_oor;
    logic [31:0]            n_pix;

    logic [ROW_W-1:0]       row;
    logic                   upper;
    logic [COLOR_W-1:0]     col_s;
    logic [COLOR_W-1:0]     col_e;
    logic [CHAN_W-1:0]      cs;
    logic [CHAN_W-1:0]      ce;
    logic [CHAN_W-1:0]      mag;
    logic [PROD_W:0]        v;
    logic [COLOR_W-1:0]     base;

    tsvg_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    always_comb begin
        ld[NUM_STAGES-1] = ~r_v[NUM_STAGES-1] | i_m_axis_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            ld[i] = ~r_v[i] | ld[i+1];
        end
    end

    assign o_s_axis_tready = ld[0];

    // Setup: pick the segment, its length and offset, and each channel's delta; then run each divider stage's steps.
    always_comb begin
        row   = i_s_axis_tdata[ROW_W-1:0];
        upper = row < cfg.split;
        col_s = upper ? cfg.top : cfg.middle;
        col_e = upper ? cfg.middle : cfg.bottom;
        n_d[0].oor  = {1'b0, row} >= cfg.height;
        n_d[0].last = ({1'b0, row} + HEIGHT_W'(1)) == cfg.height;
        n_d[0].den  = upper ? cfg.split : cfg.len_lo;
        n_d[0].k    = upper ? row : row - cfg.split;
        n_d[0].nul  = n_d[0].den == '0;
        cs  = '0;
        ce  = '0;
        mag = '0;
        for (int c = 0; c < LANES; c++) begin
            cs  = col_s[c*CHAN_W +: CHAN_W];
            ce  = col_e[c*CHAN_W +: CHAN_W];
            mag = (ce < cs) ? cs - ce : ce - cs;
            n_d[0].lane[c].rem = '0;
            n_d[0].lane[c].w   = {mag, FRAC_W'(0)};
            n_d[0].lane[c].s   = cs;
            n_d[0].lane[c].neg = ce < cs;
        end
        for (int i = 1; i <= DIV_STAGES; i++) begin
            n_d[i] = r_d[i-1];
            for (int c = 0; c < LANES; c++) begin
                n_d[i].lane[c] = div_steps(r_d[i-1].lane[c], r_d[i-1].den);
            end
        end
    end

    always_comb begin
        n_m.oor  = r_d[DIV_STAGES].oor;
        n_m.last = r_d[DIV_STAGES].last;
        for (int c = 0; c < LANES; c++) begin
            n_m.s[c]   = r_d[DIV_STAGES].lane[c].s;
            n_m.neg[c] = r_d[DIV_STAGES].lane[c].neg;
            n_m.prod[c] = r_d[DIV_STAGES].nul ? '0 :
                PROD_W'(r_d[DIV_STAGES].lane[c].w) * PROD_W'(r_d[DIV_STAGES].k);
        end
    end

    always_comb begin
        n_pix = {ALPHA_OPAQUE, COLOR_W'(0)};
        v     = '0;
        base  = '0;
        for (int c = 0; c < LANES; c++) begin
            base = {r_m.s[c], FRAC_W'(0)};
            if (r_m.neg[c]) begin
                v = (PROD_W+1)'(base) - {1'b0, r_m.prod[c]};
            end else begin
                v = (PROD_W+1)'(base) + {1'b0, r_m.prod[c]};
            end
            n_pix[c*CHAN_W +: CHAN_W] = v[PROD_W] ? '0 : v[FRAC_W +: CHAN_W];
        end
        if (r_m.oor) begin
            n_pix = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ld[0]) begin
                r_v[0] <= i_s_axis_tvalid;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (ld[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i <= DIV_STAGES; i++) begin
            if (ld[i]) begin
                r_d[i] <= n_d[i];
            end
        end
        if (ld[MUL_ST]) begin
            r_m <= n_m;
        end
        if (ld[OUT_ST]) begin
            r_pix  <= n_pix;
            r_last <= r_m.last & ~r_m.oor;
            r_oor  <= r_m.oor;
        end
    end

    assign o_m_axis_tvalid = r_v[OUT_ST];
    assign o_m_axis_tdata  = r_pix;
    assign o_m_axis_tlast  = r_last;
    assign o_m_axis_tuser  = r_oor;

    a_stall_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_v[OUT_ST] && !i_m_axis_tready))
        else $error("input held off without a stalled output");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0 && !o_m_axis_tlast))
        else $error("out-of-range row with nonzero pixel or last flag");

    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata[31:24] == ALPHA_OPAQUE))
        else $error("in-range pixel is not opaque");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Checks the two-segment vertical gradient row color block.
// Rows go in as stream transfers from a queue. A predictor in this file works
// out each row's color, last-row flag and out-of-range flag from its own copy
// of the register settings. Every result is checked in order against that
// prediction. Registers change only while the pipeline is empty. Both stream
// sides idle at random, and the sink holds off once for a long stretch.
// ============================================================================
module testbench;
    import tsvg_pkg::*;

    localparam int          HALF_PERIOD  = 2;
    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          RAND_PHASES  = 14;
    localparam int          PHASE_ROWS   = 125;
    localparam int          LONG_HOLD    = 300;
    localparam int unsigned SPLIT_MUL_C  = 132;
    localparam int unsigned SPLIT_DIV_C  = 255;
    localparam int          MAX_PRINTED  = 100;

    typedef struct packed {
        logic [31:0] color;
        logic        last;
        logic        oor;
    } t_shade;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        cfg_we     = 1'b0;
    logic [1:0]  cfg_idx    = REG_TOP_COLOR;
    logic [23:0] cfg_data   = '0;
    logic        src_valid  = 1'b0;
    logic [12:0] src_row    = '0;
    logic        snk_ready  = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [31:0] m_data;
    logic        m_last;
    logic        m_user;

    // Register copy used by the predictor.
    logic [23:0] top_rgb       = '0;
    logic [23:0] mid_rgb       = '0;
    logic [23:0] bot_rgb       = '0;
    logic [13:0] rows_in_frame = 14'd1;

    logic [12:0] pending_rows[$];
    t_shade      pending_shades[$];

    int unsigned rows_queued   = 0;
    int unsigned rows_sent     = 0;
    int unsigned results_seen  = 0;
    int unsigned oor_seen      = 0;
    int unsigned last_seen     = 0;
    int unsigned settings_used = 0;
    int unsigned mismatches    = 0;
    int unsigned cycle_count   = 0;
    int unsigned src_mode      = 0;
    int unsigned snk_mode      = 0;
    logic        long_hold_req = 1'b0;

    two_segment_vertical_gradient i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (src_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  ({3'b000, src_row}),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (snk_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .o_m_axis_tuser  (m_user)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic logic [7:0] blend_channel(logic [7:0] s, logic [7:0] e,
                                                 longint len, longint k);
        longint step;
        longint v;
        step = 0;
        if (len > 0) begin
            step = ((longint'(e) - longint'(s)) * 65536) / len;
        end
        v = longint'(s) * 65536 + step * k;
        if (v < 0) begin
            v = 0;
        end
        return 8'(v / 65536);
    endfunction

    function automatic t_shade gradient_shade(logic [12:0] row);
        t_shade      sh;
        int unsigned h;
        int unsigned split;
        h = rows_in_frame;
        sh = '0;
        if (row >= h) begin
            sh.oor = 1'b1;
            return sh;
        end
        split = (SPLIT_MUL_C * (h - 1)) / SPLIT_DIV_C;
        for (int i = 0; i < 3; i++) begin
            if (row < split) begin
                sh.color[8*i +: 8] = blend_channel(top_rgb[8*i +: 8], mid_rgb[8*i +: 8],
                                                   longint'(split), longint'(row));
            end else begin
                sh.color[8*i +: 8] = blend_channel(mid_rgb[8*i +: 8], bot_rgb[8*i +: 8],
                                                   longint'(h) - longint'(split) - 1,
                                                   longint'(row) - longint'(split));
            end
        end
        sh.color[31:24] = 8'hFF;
        sh.last = (row + 1 == h);
        return sh;
    endfunction

    function automatic int unsigned draw_wait(int unsigned mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 17);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
        endcase
    endfunction

    function automatic logic [23:0] random_color();
        logic [23:0] c;
        for (int i = 0; i < 3; i++) begin
            case ($urandom_range(0, 5))
                0:       c[8*i +: 8] = 8'h00;
                1:       c[8*i +: 8] = 8'hFF;
                default: c[8*i +: 8] = 8'($urandom);
            endcase
        end
        return c;
    endfunction

    function automatic logic [23:0] random_height_word();
        logic [13:0] h;
        case ($urandom_range(0, 9))
            0:       h = 14'(MAX_ROWS);
            1:       h = 14'($urandom_range(MAX_ROWS + 1, 16383));
            2:       h = ($urandom_range(0, 3) == 0) ? 14'd0 : 14'd1;
            3, 4, 5: h = 14'($urandom_range(1, 16));
            default: h = 14'($urandom_range(1, MAX_ROWS));
        endcase
        return {10'($urandom), h};
    endfunction

    function automatic logic [12:0] pick_row();
        int unsigned h;
        int unsigned split;
        int unsigned sel;
        h = rows_in_frame;
        sel = $urandom_range(0, 9);
        if (h == 0 || sel < 2) begin
            return 13'($urandom);
        end
        split = (SPLIT_MUL_C * (h - 1)) / SPLIT_DIV_C;
        if (sel < 4) begin
            case ($urandom_range(0, 4))
                0:       return 13'((split > 0) ? split - 1 : 0);
                1:       return 13'(split);
                2:       return 13'(h - 1);
                3:       return 13'((h < MAX_ROWS) ? h : MAX_ROWS - 1);
                default: return 13'd0;
            endcase
        end
        return 13'($urandom_range(0, h - 1));
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatches < MAX_PRINTED) begin
            $display("%0t: %s mismatch at result %0d: got %h, expected %h",
                     $realtime, what, results_seen, got, want);
        end
        mismatches++;
    endtask

    task automatic write_reg(t_reg_idx idx, logic [23:0] value);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = value;
        @(posedge i_clk);
        case (idx)
            REG_TOP_COLOR:    top_rgb = value;
            REG_MIDDLE_COLOR: mid_rgb = value;
            REG_BOTTOM_COLOR: bot_rgb = value;
            REG_FRAME_HEIGHT: rows_in_frame = (value[13:0] > MAX_ROWS) ?
                                              14'(MAX_ROWS) : value[13:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic queue_row(logic [12:0] row);
        pending_rows.push_back(row);
        rows_queued++;
    endtask

    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (rows_sent != rows_queued || pending_shades.size() != 0);
    endtask

    task automatic set_colors(logic [23:0] top, logic [23:0] middle, logic [23:0] bottom);
        write_reg(REG_TOP_COLOR, top);
        write_reg(REG_MIDDLE_COLOR, middle);
        write_reg(REG_BOTTOM_COLOR, bottom);
        settings_used++;
    endtask

    // Cycle limit, and input side: prediction on each accepted transfer.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (i_rst_n && src_valid && s_ready) begin
            pending_shades.push_back(gradient_shade(src_row));
            rows_sent++;
        end
    end

    // Input side: presents queued rows with random gaps.
    always @(negedge i_clk) begin
        int unsigned taken;
        int unsigned gap;
        logic        nv;
        logic [12:0] nrow;
        nv = src_valid;
        nrow = src_row;
        if (i_rst_n) begin
            if (rows_sent != taken) begin
                taken = rows_sent;
                nv = 1'b0;
            end
            if (!nv) begin
                if (gap > 0) begin
                    gap--;
                end else if (pending_rows.size() != 0) begin
                    nrow = pending_rows.pop_front();
                    nv = 1'b1;
                    gap = draw_wait(src_mode);
                end
            end
        end
        src_valid <= nv;
        src_row   <= nrow;
    end

    // Output side: ready with random stalls and one long hold-off on request.
    always @(negedge i_clk) begin
        int unsigned seen;
        int unsigned wait_left;
        int unsigned hold_left;
        bit          hold_ack;
        logic        nr;
        nr = 1'b0;
        if (i_rst_n) begin
            if (long_hold_req != hold_ack) begin
                hold_ack = long_hold_req;
                hold_left = LONG_HOLD;
            end
            if (results_seen != seen) begin
                seen = results_seen;
                wait_left = draw_wait(snk_mode);
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (wait_left > 0) begin
                wait_left--;
            end else begin
                nr = 1'b1;
            end
        end
        snk_ready <= nr;
    end

    // Output side: compares each transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_shade want;
        if (i_rst_n && m_valid && snk_ready) begin
            results_seen++;
            if (m_user) begin
                oor_seen++;
            end
            if (m_last) begin
                last_seen++;
            end
            if (pending_shades.size() == 0) begin
                report_mismatch("unexpected result", m_data, 32'h0);
            end else begin
                want = pending_shades.pop_front();
                if (m_data !== want.color) begin
                    report_mismatch("pixel_color", m_data, want.color);
                end
                if (m_last !== want.last) begin
                    report_mismatch("last_row", 32'(m_last), 32'(want.last));
                end
                if (m_user !== want.oor) begin
                    report_mismatch("out_of_range", 32'(m_user), 32'(want.oor));
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        // Default settings: one row, black colors.
        settings_used++;
        queue_row(13'd0);
        queue_row(13'd1);
        queue_row(13'd8191);
        wait_idle();

        // Full-swing colors with a height word that saturates to the limit.
        set_colors(24'hFFFFFF, 24'h000000, 24'hFFFFFF);
        write_reg(REG_FRAME_HEIGHT, 24'hFFFFFF);
        queue_row(13'd0);
        queue_row(13'd4239);
        queue_row(13'd4240);
        queue_row(13'd4241);
        queue_row(13'd8190);
        queue_row(13'd8191);
        wait_idle();

        // Zero height: every row is out of range.
        write_reg(REG_FRAME_HEIGHT, 24'd0);
        queue_row(13'd0);
        queue_row(13'd5);
        wait_idle();

        // Two rows: both fall in the lower segment.
        set_colors(24'h123456, 24'hABCDEF, 24'h00FF80);
        write_reg(REG_FRAME_HEIGHT, 24'd2);
        queue_row(13'd0);
        queue_row(13'd1);
        queue_row(13'd2);
        wait_idle();

        // Three rows: one upper row, and a lower segment of one step.
        write_reg(REG_FRAME_HEIGHT, 24'd3);
        queue_row(13'd0);
        queue_row(13'd1);
        queue_row(13'd2);
        queue_row(13'd3);
        wait_idle();

        // One row: the lower segment has zero length and takes the middle color.
        write_reg(REG_FRAME_HEIGHT, 24'd1);
        queue_row(13'd0);
        queue_row(13'd1);
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            set_colors(random_color(), random_color(), random_color());
            write_reg(REG_FRAME_HEIGHT, random_height_word());
            src_mode = $urandom_range(0, 2);
            snk_mode = $urandom_range(0, 2);
            if (p == 3) begin
                src_mode = 0;
                long_hold_req = ~long_hold_req;
            end
            for (int n = 0; n < PHASE_ROWS; n++) begin
                if (p == 6 && n == PHASE_ROWS / 2) begin
                    wait_idle();
                end
                queue_row(pick_row());
            end
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        $display("Checked %0d rows over %0d register settings", results_seen, settings_used);
        $display("Out-of-range rows: %0d, last rows: %0d", oor_seen, last_seen);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
